// ===== rtl/iee_pkg.sv =====
package iee_pkg;

    // Widths of the datapath and the payload fields.
    localparam int unsigned WordWidth   = 32;
    localparam int unsigned SymbolWidth = 8;

    // Operator codes held as the pending operator.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // ASCII characters recognized on the input.
    localparam logic [SymbolWidth-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SymbolWidth-1:0] CH_MINUS = 8'h2D;
    localparam logic [SymbolWidth-1:0] CH_STAR  = 8'h2A;
    localparam logic [SymbolWidth-1:0] CH_SLASH = 8'h2F;
    localparam logic [SymbolWidth-1:0] CH_ZERO  = 8'h30;
    localparam logic [SymbolWidth-1:0] CH_NINE  = 8'h39;

    // Status that the divider reports back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/iee_divider.sv =====
module iee_divider
    import iee_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WordWidth-1:0] dividend,
    input  logic [WordWidth-1:0] divisor,
    output div_stat_t            stat,
    output logic [WordWidth-1:0] quotient
);

    localparam int unsigned CntWidth = $clog2(WordWidth);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CntWidth-1:0]  cnt_reg;
    logic [CntWidth-1:0]  cnt_next;
    logic [WordWidth-1:0] rem_reg;
    logic [WordWidth-1:0] rem_next;
    logic [WordWidth-1:0] quo_reg;
    logic [WordWidth-1:0] quo_next;
    logic [WordWidth-1:0] dvs_reg;
    logic [WordWidth-1:0] dvs_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic [WordWidth:0]   shifted;
    logic [WordWidth:0]   trial;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[WordWidth-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            // Load magnitudes and remember the sign of the quotient.
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[WordWidth-1] ? (~dividend + 1'b1) : dividend;
            dvs_next  = divisor[WordWidth-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[WordWidth-1] ^ divisor[WordWidth-1];
        end
        else if (busy_reg)
        begin
            if (!trial[WordWidth])
            begin
                rem_next = trial[WordWidth-1:0];
                quo_next = {quo_reg[WordWidth-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WordWidth-1:0];
                quo_next = {quo_reg[WordWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntWidth'(WordWidth - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Truncation toward zero: negate the magnitude quotient when signs differ.
    assign quotient  = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/infix_expression_evaluator.sv =====
// Evaluates an integer expression with + - * / and the usual precedence, taken
// one ASCII character per transfer on the slave side, with tlast on the final
// character. Digits build a decimal number, spaces and unknown characters are
// skipped, and an operator or the final character commits the number under the
// pending operator. One result transfer leaves per expression: the 32-bit
// wrapped value in tdata and a division-by-zero flag in tuser; the block then
// returns to its reset state. Digits and spaces are taken in the idle state. An
// operator or final character then passes the commit step, and a divide by a
// nonzero number also waits on the radix-2 divider, one quotient bit per cycle.
// The final character adds an emit step to load the output register, which waits
// while the previous result has not yet been taken.
module infix_expression_evaluator
    import iee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,   // end_of_expr
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [0:0]  m_axis_tuser    // [0] div_by_zero
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_COMMIT = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [WordWidth-1:0] sum_reg;
    logic [WordWidth-1:0] sum_next;
    logic [WordWidth-1:0] term_reg;
    logic [WordWidth-1:0] term_next;
    logic [WordWidth-1:0] num_reg;
    logic [WordWidth-1:0] num_next;
    logic [1:0]           pend_reg;
    logic [1:0]           pend_next;
    logic                 err_reg;
    logic                 err_next;
    logic [1:0]           new_op_reg;
    logic [1:0]           new_op_next;
    logic                 is_op_reg;
    logic                 is_op_next;
    logic                 end_reg;
    logic                 end_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WordWidth-1:0] out_value_reg;
    logic [WordWidth-1:0] out_value_next;
    logic                 out_err_reg;
    logic                 out_err_next;

    logic                   in_xfer;
    logic                   is_digit;
    logic                   is_op;
    logic [1:0]             op_code;
    logic [WordWidth-1:0]   digit_val;
    logic [2*WordWidth-1:0] product;
    logic                   finish;
    logic                   div_start;
    div_stat_t              div_stat;
    logic [WordWidth-1:0]   div_quot;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Character decode.
    assign is_digit  = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
    assign digit_val = WordWidth'(s_axis_tdata - CH_ZERO);

    always_comb
    begin
        is_op   = 1'b1;
        op_code = OP_ADD;
        unique case (s_axis_tdata)
            CH_PLUS:  op_code = OP_ADD;
            CH_MINUS: op_code = OP_SUB;
            CH_STAR:  op_code = OP_MUL;
            CH_SLASH: op_code = OP_DIV;
            default:  is_op   = 1'b0;
        endcase
    end

    assign product = term_reg * num_reg;

    iee_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (term_reg),
        .divisor  (num_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Sequencer and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        term_next      = term_reg;
        num_next       = num_reg;
        pend_next      = pend_reg;
        err_next       = err_reg;
        new_op_next    = new_op_reg;
        is_op_next     = is_op_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        finish         = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    // Decimal accumulate: num * 10 + digit, wrapping.
                    if (is_digit)
                    begin
                        num_next = {num_reg[WordWidth-4:0], 3'b000}
                                 + {num_reg[WordWidth-2:0], 1'b0} + digit_val;
                    end
                    new_op_next = op_code;
                    is_op_next  = is_op;
                    end_next    = s_axis_tlast;
                    if (is_op || s_axis_tlast)
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT:
            begin
                unique case (pend_reg)
                    OP_ADD:
                    begin
                        sum_next  = sum_reg + term_reg;
                        term_next = num_reg;
                        finish    = 1'b1;
                    end
                    OP_SUB:
                    begin
                        sum_next  = sum_reg + term_reg;
                        term_next = ~num_reg + 1'b1;
                        finish    = 1'b1;
                    end
                    OP_MUL:
                    begin
                        term_next = product[WordWidth-1:0];
                        finish    = 1'b1;
                    end
                    OP_DIV:
                    begin
                        if (num_reg == '0)
                        begin
                            term_next = '0;
                            err_next  = 1'b1;
                            finish    = 1'b1;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    term_next = div_quot;
                    finish    = 1'b1;
                end
            end
            ST_EMIT:
            begin
                // Load the result once the output register is free, then clear.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = sum_reg + term_reg;
                    out_err_next   = err_reg;
                    sum_next       = '0;
                    term_next      = '0;
                    num_next       = '0;
                    pend_next      = OP_ADD;
                    err_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // End of a commit: clear the number and take up the new operator.
        if (finish)
        begin
            num_next = '0;
            if (is_op_reg)
            begin
                pend_next = new_op_reg;
            end
            state_next = end_reg ? ST_EMIT : ST_IDLE;
        end
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            term_reg      <= '0;
            num_reg       <= '0;
            pend_reg      <= OP_ADD;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            term_reg      <= term_next;
            num_reg       <= num_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Latched character info and output payload.
    always_ff @(posedge clk)
    begin
        new_op_reg    <= new_op_next;
        is_op_reg     <= is_op_next;
        end_reg       <= end_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_value_reg;
    assign m_axis_tuser[0] = out_err_reg;

    // The divider is only started when it is free.
    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A divider result only arrives while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider result outside the divide wait");

    // A new result only appears after the emit step.
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_EMIT))
        else $error("result presented without an emit step");

    // No input is taken while a commit is in progress.
    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_COMMIT) || (state_reg == ST_DIV)) |-> !s_axis_tready)
        else $error("input accepted during a commit");

endmodule

// ===== tb/tb_infix_expression_evaluator.sv =====
`timescale 1ns / 1ps

module tb_infix_expression_evaluator;
    import iee_pkg::*;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam int ItemTarget = 700;
    localparam int IdlePct = 29;
    localparam int HoldCycles = 500;

    // Expected result of one expression.
    typedef struct {
        logic [31:0] value;
        logic        div_zero;
    } calc_result_t;

    // Tracks the evaluator state symbol by symbol and checks each result transfer.
    class calc_scoreboard;
        logic [31:0]  sum_acc;
        logic [31:0]  term_acc;
        logic [31:0]  num_acc;
        logic [1:0]   op_pending;
        logic         div_zero_seen;
        calc_result_t pending_results[$];
        int           error_count;

        function new();
            error_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            sum_acc = '0;
            term_acc = '0;
            num_acc = '0;
            op_pending = OP_ADD;
            div_zero_seen = 1'b0;
        endfunction

        // Signed division on raw words, truncated toward zero, wrapping on overflow.
        function logic [31:0] quotient_toward_zero(logic [31:0] a, logic [31:0] b);
            logic [31:0] mag_a;
            logic [31:0] mag_b;
            logic [31:0] q;
            mag_a = a[31] ? 32'd0 - a : a;
            mag_b = b[31] ? 32'd0 - b : b;
            q = mag_a / mag_b;
            return (a[31] != b[31]) ? 32'd0 - q : q;
        endfunction

        // Applies the number just built under the pending operator.
        function void commit_number();
            case (op_pending)
                OP_ADD:
                begin
                    sum_acc = sum_acc + term_acc;
                    term_acc = num_acc;
                end
                OP_SUB:
                begin
                    sum_acc = sum_acc + term_acc;
                    term_acc = 32'd0 - num_acc;
                end
                OP_MUL:
                begin
                    term_acc = term_acc * num_acc;
                end
                default:
                begin
                    if (num_acc == 32'd0)
                    begin
                        term_acc = '0;
                        div_zero_seen = 1'b1;
                    end
                    else
                    begin
                        term_acc = quotient_toward_zero(term_acc, num_acc);
                    end
                end
            endcase
            num_acc = '0;
        endfunction

        // Called for every accepted input transfer.
        function void note_symbol(logic [7:0] sym, logic last);
            logic         is_digit;
            logic         is_op;
            calc_result_t res;
            is_digit = (sym >= CH_ZERO) && (sym <= CH_NINE);
            is_op = (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_STAR)
                    || (sym == CH_SLASH);
            if (is_digit)
            begin
                num_acc = num_acc * 32'd10 + {24'd0, sym - CH_ZERO};
            end
            if (is_op || last)
            begin
                commit_number();
                if (sym == CH_PLUS)
                    op_pending = OP_ADD;
                else if (sym == CH_MINUS)
                    op_pending = OP_SUB;
                else if (sym == CH_STAR)
                    op_pending = OP_MUL;
                else if (sym == CH_SLASH)
                    op_pending = OP_DIV;
            end
            if (last)
            begin
                res.value = sum_acc + term_acc;
                res.div_zero = div_zero_seen;
                pending_results.push_back(res);
                clear_state();
            end
        endfunction

        // Called for every accepted output transfer.
        function void check_result(logic [31:0] value, logic div_zero);
            calc_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got value %0d flag %0b",
                         $time, $signed(value), div_zero);
                error_count++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (value !== exp_res.value)
            begin
                $display("%0t: value mismatch, expected %0d, got %0d",
                         $time, $signed(exp_res.value), $signed(value));
                error_count++;
            end
            if (div_zero !== exp_res.div_zero)
            begin
                $display("%0t: div_by_zero mismatch, expected %0b, got %0b",
                         $time, exp_res.div_zero, div_zero);
                error_count++;
            end
        endfunction

        function void flag_leftover();
            if (pending_results.size() != 0)
            begin
                $display("%0t: %0d results never arrived, expected value %0d first",
                         $time, pending_results.size(), $signed(pending_results[0].value));
                error_count++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] symbol
    logic        s_axis_tlast = 1'b0;   // end_of_expr
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] value
    logic [0:0]  m_axis_tuser;          // [0] div_by_zero

    calc_scoreboard sb = new();
    int items_sent = 0;
    int src_idle_pct = IdlePct;
    int sink_idle_pct = IdlePct;
    bit hold_request = 1'b0;

    infix_expression_evaluator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // Offers one symbol, starting and ending at a falling edge.
    task automatic send_symbol(input logic [7:0] sym, input logic last);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sym;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_symbol(sym, last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_symbol(text[i], i == text.len() - 1);
    endtask

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Mostly well-formed expressions with random content, some pure noise.
    task automatic send_random_expr();
        logic [7:0] syms[$];
        int         terms;
        int         digits;
        int         pick;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                syms.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            terms = $urandom_range(1, 5);
            for (int t = 0; t < terms; t++)
            begin
                if (t > 0)
                    syms.push_back(pick_operator());
                if ($urandom_range(0, 3) == 0)
                    syms.push_back(CH_SPACE);
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    digits = 0;
                else if (pick == 1)
                    digits = $urandom_range(10, 12);
                else
                    digits = $urandom_range(1, 3);
                repeat (digits)
                    syms.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 19) == 0)
                    syms.push_back(8'($urandom_range(0, 255)));
            end
            // Occasionally end on something other than a digit.
            pick = $urandom_range(0, 9);
            if (pick == 0)
                syms.push_back(CH_SPACE);
            else if (pick == 1)
                syms.push_back(pick_operator());
            else if (pick == 2)
                syms.push_back(8'($urandom_range(0, 255)));
        end
        if (syms.size() == 0)
            syms.push_back(CH_SPACE);
        for (int i = 0; i < syms.size(); i++)
            send_symbol(syms[i], i == syms.size() - 1);
    endtask

    // Result receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                stall_left = HoldCycles;
                hold_request = 1'b0;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    // Main stimulus.
    initial
    begin
        int  drain;
        bit  hold_done;
        hold_done = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Most negative value divided by -1, with a leading operator and no number.
        send_text("-2147483648/4294967295");
        // Every operator, division by zero, and a space as the final character.
        send_text("9*8-7+6/0 ");
        // Operator with no number, then an operator as the final character.
        send_text("1+*");
        // Symbol extremes: skipped NUL mid-expression, unknown 0xFF at the end.
        send_symbol(8'h00, 1'b0);
        send_symbol(CH_ZERO + 8'd5, 1'b0);
        send_symbol(8'hFF, 1'b1);

        while (items_sent < ItemTarget)
        begin
            if (!hold_done && items_sent >= 150)
            begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            // A stretch with no idling on either side.
            if (items_sent >= 300 && items_sent < 420)
            begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            else
            begin
                src_idle_pct = IdlePct;
                sink_idle_pct = IdlePct;
            end
            send_random_expr();
        end
        s_axis_tvalid <= 1'b0;
        sink_idle_pct = IdlePct;

        drain = 0;
        while (sb.pending_results.size() != 0 && drain < 50000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (100) @(posedge clk);
        sb.flag_leftover();
        if (sb.error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run limit.
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
